[rtl/tasp_pkg.sv]
package tasp_pkg;

    // default scenario table size
    localparam int TASP_TABLE_DEPTH = 20;

    // field widths
    localparam int MODE_W = 2;
    localparam int CHAR_W = 8;
    localparam int UNIT_W = 4;
    localparam int CMD_W  = 4;
    localparam int TIME_W = 12;
    localparam int POS_W  = 3;

    // input mode codes
    localparam logic [MODE_W-1:0] MODE_CHAR    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_RESTART = 2'd1;
    localparam logic [MODE_W-1:0] MODE_TICK    = 2'd2;

    // result kind codes
    localparam logic KIND_ACTION = 1'b0;
    localparam logic KIND_PULSE  = 1'b1;

    // character codes
    localparam logic [CHAR_W-1:0] CH_A = 8'h41;
    localparam logic [CHAR_W-1:0] CH_C = 8'h43;
    localparam logic [CHAR_W-1:0] CH_P = 8'h50;
    localparam logic [CHAR_W-1:0] CH_N = 8'h4E;
    localparam logic [CHAR_W-1:0] CH_B = 8'h42;
    localparam logic [CHAR_W-1:0] CH_I = 8'h49;
    localparam logic [CHAR_W-1:0] CH_T = 8'h54;
    localparam logic [CHAR_W-1:0] CH_S = 8'h53;
    localparam logic [CHAR_W-1:0] CMD_OFFSET = 8'd63;

    // unit codes
    localparam logic [UNIT_W-1:0] UNIT_A    = 4'd1;
    localparam logic [UNIT_W-1:0] UNIT_C    = 4'd2;
    localparam logic [UNIT_W-1:0] UNIT_P    = 4'd4;
    localparam logic [UNIT_W-1:0] UNIT_N    = 4'd8;
    localparam logic [UNIT_W-1:0] UNIT_NONE = 4'd0;

    // command codes
    localparam logic [CMD_W-1:0] CMD_OFF = 4'd0;
    localparam logic [CMD_W-1:0] CMD_ON  = 4'd1;

    // record character positions
    localparam logic [POS_W-1:0] POS_UNIT   = 3'd1;
    localparam logic [POS_W-1:0] POS_CMD    = 3'd2;
    localparam logic [POS_W-1:0] POS_DIG_HI = 3'd3;
    localparam logic [POS_W-1:0] POS_DIG_MD = 3'd4;
    localparam logic [POS_W-1:0] POS_DIG_LO = 3'd5;

    // one stored action
    typedef struct packed {
        logic [UNIT_W-1:0] unit;
        logic [CMD_W-1:0]  command;
        logic [TIME_W-1:0] action_time;
    } entry_t;

    // controller to datapath
    typedef struct packed {
        logic char_take;
        logic scen_restart;
        logic tick_take;
        logic rd_en;
        logic load_entry;
        logic load_pulse;
        logic set_last;
        logic last_val;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic full;
        logic match;
        logic circle_end;
    } dp_status_t;

endpackage

[rtl/tasp_dp.sv]
module tasp_dp
    import tasp_pkg::*;
#(
    parameter int TABLE_DEPTH = TASP_TABLE_DEPTH
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  dp_cmd_t           cmd,
    output dp_status_t        status,
    input  logic [CHAR_W-1:0] char_in,
    input  logic [TIME_W-1:0] tick_time,
    output logic              kind,
    output logic [UNIT_W-1:0] unit,
    output logic [CMD_W-1:0]  command,
    output logic [TIME_W-1:0] action_time,
    output logic              last
);

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_C   = CNT_W'(TABLE_DEPTH);
    localparam logic [CNT_W-1:0] DEPTH_M1  = CNT_W'(TABLE_DEPTH - 1);
    localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(TABLE_DEPTH - 1);

    // parser state
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [UNIT_W-1:0] pend_unit_reg, pend_unit_next;
    logic [CMD_W-1:0]  pend_cmd_reg, pend_cmd_next;
    logic [TIME_W-1:0] pend_time_reg, pend_time_next;

    // playback state
    logic [IDX_W-1:0]  ptr_reg, ptr_next;
    logic [CNT_W-1:0]  walk_reg, walk_next;
    logic [TIME_W-1:0] tick_reg;

    // table storage and read port
    entry_t                 mem [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] vld_reg, vld_next;
    entry_t                 rd_data_reg;
    logic                   rd_vld_reg;
    entry_t                 rd_entry;

    logic                   wr_en;
    entry_t                 wr_data;
    logic [3:0]             digit;

    assign digit = char_in[3:0];

    // record parser
    always_comb
    begin
        pos_next       = pos_reg;
        count_next     = count_reg;
        pend_unit_next = pend_unit_reg;
        pend_cmd_next  = pend_cmd_reg;
        pend_time_next = pend_time_reg;
        wr_en          = 1'b0;
        if (cmd.scen_restart)
        begin
            pos_next   = POS_UNIT;
            count_next = '0;
        end
        else if (cmd.char_take)
        begin
            pos_next = pos_reg + 3'd1;
            case (pos_reg)
                POS_UNIT:
                begin
                    if (char_in == CH_A)      pend_unit_next = UNIT_A;
                    else if (char_in == CH_C) pend_unit_next = UNIT_C;
                    else if (char_in == CH_P) pend_unit_next = UNIT_P;
                    else if (char_in == CH_N) pend_unit_next = UNIT_N;
                    else                      pend_unit_next = UNIT_NONE;
                end
                POS_CMD:
                begin
                    if (char_in >= CH_B && char_in <= CH_I)
                        pend_cmd_next = CMD_W'(char_in - CMD_OFFSET);
                    else if (char_in == CH_T)
                        pend_cmd_next = CMD_ON;
                    else if (char_in == CH_S)
                        pend_cmd_next = CMD_OFF;
                end
                POS_DIG_HI: pend_time_next = {digit, 8'd0};
                POS_DIG_MD: pend_time_next = pend_time_reg | {4'd0, digit, 4'd0};
                POS_DIG_LO:
                begin
                    pend_time_next = pend_time_reg | {8'd0, digit};
                    pos_next       = POS_UNIT;
                    if (count_reg < DEPTH_C)
                    begin
                        wr_en      = 1'b1;
                        count_next = count_reg + 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    assign wr_data = '{unit: pend_unit_reg, command: pend_cmd_reg,
                       action_time: pend_time_reg | {8'd0, digit}};

    // valid bits per table entry
    always_comb
    begin
        vld_next = vld_reg;
        if (wr_en)
            vld_next[count_reg[IDX_W-1:0]] = 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[count_reg[IDX_W-1:0]] <= wr_data;
        if (cmd.rd_en)
            rd_data_reg <= mem[ptr_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rd_vld_reg <= 1'b0;
        else if (cmd.rd_en)
            rd_vld_reg <= vld_reg[ptr_reg];
    end

    // an entry never written reads as zero
    assign rd_entry = rd_vld_reg ? rd_data_reg : '0;

    // play pointer and walk count
    always_comb
    begin
        ptr_next  = ptr_reg;
        walk_next = walk_reg;
        if (cmd.load_pulse)
            ptr_next = '0;
        if (cmd.tick_take)
            walk_next = '0;
        if (cmd.load_entry)
        begin
            ptr_next  = (ptr_reg == LAST_IDX) ? '0 : ptr_reg + 1'b1;
            walk_next = walk_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            count_reg     <= '0;
            pend_unit_reg <= '0;
            pend_cmd_reg  <= '0;
            pend_time_reg <= '0;
            ptr_reg       <= '0;
            walk_reg      <= '0;
            vld_reg       <= '0;
        end
        else
        begin
            pos_reg       <= pos_next;
            count_reg     <= count_next;
            pend_unit_reg <= pend_unit_next;
            pend_cmd_reg  <= pend_cmd_next;
            pend_time_reg <= pend_time_next;
            ptr_reg       <= ptr_next;
            walk_reg      <= walk_next;
            vld_reg       <= vld_next;
        end
    end

    // tick capture
    always_ff @(posedge clk)
    begin
        if (cmd.tick_take)
            tick_reg <= tick_time;
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (cmd.load_pulse)
        begin
            kind        <= KIND_PULSE;
            unit        <= '0;
            command     <= '0;
            action_time <= '0;
            last        <= 1'b1;
        end
        else if (cmd.load_entry)
        begin
            kind        <= KIND_ACTION;
            unit        <= rd_entry.unit;
            command     <= rd_entry.command;
            action_time <= rd_entry.action_time;
            last        <= cmd.last_val;
        end
        else if (cmd.set_last)
        begin
            last <= cmd.last_val;
        end
    end

    // status towards the controller
    assign status.full       = (count_reg >= DEPTH_C);
    assign status.match      = (rd_entry.action_time == tick_reg);
    assign status.circle_end = (walk_reg == DEPTH_M1);

endmodule

[rtl/tasp_ctrl.sv]
module tasp_ctrl
    import tasp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_ready,
    input  logic [MODE_W-1:0] mode,
    output logic              result_valid,
    input  logic              result_ready,
    output dp_cmd_t           cmd,
    input  dp_status_t        status
);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_CHAR = 5'b00010,
        ST_RD   = 5'b00100,
        ST_CMP  = 5'b01000,
        ST_OUT  = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    logic   held_reg, held_next;
    logic   take;
    logic   cmd_last_q;

    assign item_ready   = (state_reg == ST_IDLE);
    assign result_valid = (state_reg == ST_OUT);
    assign take         = item_valid && item_ready;

    // sequencing of parse and playback
    always_comb
    begin
        state_next = state_reg;
        held_next  = held_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (take)
                begin
                    if (mode == MODE_CHAR)
                    begin
                        cmd.char_take = 1'b1;
                        state_next    = ST_CHAR;
                    end
                    else if (mode == MODE_RESTART)
                    begin
                        cmd.scen_restart = 1'b1;
                    end
                    else if (mode == MODE_TICK)
                    begin
                        cmd.tick_take = 1'b1;
                        held_next     = 1'b0;
                        state_next    = ST_RD;
                    end
                end
            end
            ST_CHAR:
            begin
                if (status.full)
                begin
                    cmd.load_pulse = 1'b1;
                    state_next     = ST_OUT;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_RD:
            begin
                cmd.rd_en  = 1'b1;
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                if (held_reg)
                begin
                    // look-ahead decides whether the held result is the final one
                    cmd.set_last = 1'b1;
                    cmd.last_val = !status.match;
                    state_next   = ST_OUT;
                end
                else if (!status.match)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    cmd.load_entry = 1'b1;
                    cmd.last_val   = status.circle_end;
                    held_next      = 1'b1;
                    state_next     = status.circle_end ? ST_OUT : ST_RD;
                end
            end
            ST_OUT:
            begin
                if (result_ready)
                begin
                    held_next = 1'b0;
                    // a non-final result means the next entry already matched
                    if (cmd_last_q)
                        state_next = ST_IDLE;
                    else
                        state_next = ST_CMP;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // copy of the last flag held in the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cmd_last_q <= 1'b0;
        else if (cmd.load_pulse)
            cmd_last_q <= 1'b1;
        else if (cmd.load_entry || cmd.set_last)
            cmd_last_q <= cmd.last_val;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            held_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            held_reg  <= held_next;
        end
    end

endmodule

[rtl/timed_action_scenario_player.sv]
// Timed action scenario player: stores up to TABLE_DEPTH timed actions parsed from
// 5-character records (unit letter, command letter, three time digits) and plays
// them back on time ticks. One transaction is taken at a time. A character moves
// the parser on, and once the table is full it also loads the timer-start pulse.
// A tick that matches nothing returns to idle after one table read; otherwise each
// action sent passes the registered read port of the action table and the
// one-entry look-ahead that marks the final action, and any output stall holds
// it. After a full circle of matches the final action skips the look-ahead.
// The table holds valid bits cleared by reset, so no clearing pass is needed.
module timed_action_scenario_player
    import tasp_pkg::*;
#(
    parameter int TABLE_DEPTH = TASP_TABLE_DEPTH
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_ready,
    input  logic [MODE_W-1:0] mode,
    input  logic [CHAR_W-1:0] char_in,
    input  logic [TIME_W-1:0] tick_time,
    output logic              result_valid,
    input  logic              result_ready,
    output logic              kind,
    output logic [UNIT_W-1:0] unit,
    output logic [CMD_W-1:0]  command,
    output logic [TIME_W-1:0] action_time,
    output logic              last
);

    dp_cmd_t    cmd;
    dp_status_t status;

    // control sequencer
    tasp_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .mode         (mode),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .cmd          (cmd),
        .status       (status)
    );

    // parser, table and result register
    tasp_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .char_in     (char_in),
        .tick_time   (tick_time),
        .kind        (kind),
        .unit        (unit),
        .command     (command),
        .action_time (action_time),
        .last        (last)
    );

endmodule
